/* sv/gcr_pkg.sv */
// ----------------------------------------------------------------------------
// gcr_pkg
// Types and constants for the grid ray caster: word formats, command codes,
// the controller's states and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gcr_pkg;

	localparam int DIM_W   = 13;
	localparam int POS_W   = 45;
	localparam int TRIG_W  = 18;
	localparam int STEP_W  = 12;
	localparam int QUO_W   = 42;

	localparam logic       CMD_WRITE = 1'b0;
	localparam logic       CMD_CAST  = 1'b1;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_CELL   = 2'd2;

	localparam logic signed [7:0] OCC_LIMIT = 8'sd50;
	localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;

	localparam logic [17:0] RANGE_MAX = 18'h3FFFF;
	localparam logic [8:0]  STEPS_MAX = 9'h1FF;

	typedef struct packed {
		logic              command;
		logic [15:0]       cell_index;
		logic signed [7:0] cell_value;
		logic [17:0]       pos_x;
		logic [17:0]       pos_y;
		logic [15:0]       angle;
		logic [7:0]        beam_index;
	} req_t;

	typedef struct packed {
		logic [17:0] range;
		logic [8:0]  steps;
		logic        left_grid;
		logic [7:0]  beam_tag;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_STEP,
		ST_READ,
		ST_DONE
	} state_t;

	function automatic logic [29:0] atan_turn(input logic [3:0] i);
		logic [29:0] r;
		case (i)
			4'd0:    r = 30'd536870912;
			4'd1:    r = 30'd316933406;
			4'd2:    r = 30'd167458907;
			4'd3:    r = 30'd85004756;
			4'd4:    r = 30'd42667331;
			4'd5:    r = 30'd21354465;
			4'd6:    r = 30'd10679838;
			4'd7:    r = 30'd5340245;
			4'd8:    r = 30'd2670163;
			4'd9:    r = 30'd1335087;
			4'd10:   r = 30'd667544;
			4'd11:   r = 30'd333772;
			4'd12:   r = 30'd166886;
			4'd13:   r = 30'd83443;
			4'd14:   r = 30'd41722;
			default: r = 30'd20861;
		endcase
		return r;
	endfunction

endpackage

/* sv/gcr_div.sv */
// ----------------------------------------------------------------------------
// gcr_div
// Restoring divider, one quotient bit per cycle, for the origin in cells.
// ----------------------------------------------------------------------------
module gcr_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gcr_pkg::QUO_W-1:0] dividend,
	input  logic [15:0]               divisor,
	output logic [gcr_pkg::QUO_W-1:0] quotient,
	output logic                      done
);
	logic [gcr_pkg::QUO_W-1:0] quo_q;
	logic [16:0]               rem_q;
	logic [15:0]               dvs_q;
	logic [5:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [16:0]               rem_sh;
	logic                      take;

	assign rem_sh = {rem_q[15:0], quo_q[gcr_pkg::QUO_W-1]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'(gcr_pkg::QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[gcr_pkg::QUO_W-2:0], take};
			rem_q <= take ? rem_sh - {1'b0, dvs_q} : rem_sh;
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

/* sv/gcr_cordic.sv */
// ----------------------------------------------------------------------------
// gcr_cordic
// Iterative sixteen-step CORDIC giving cosine and sine in signed Q1.16.
// ----------------------------------------------------------------------------
module gcr_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [15:0]                       angle,
	output logic signed [gcr_pkg::TRIG_W-1:0] cos_o,
	output logic signed [gcr_pkg::TRIG_W-1:0] sin_o,
	output logic                              done
);
	logic signed [19:0] x_q, y_q, dx, dy, xc, yc;
	logic signed [31:0] z_q, at;
	logic [1:0]         quad_q;
	logic [3:0]         it_q;
	logic               busy_q;
	logic               done_q;

	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign at = $signed({2'b00, gcr_pkg::atan_turn(it_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			it_q   <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 4'd1;
			if (it_q == 4'd15) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= 20'sd39797;
			y_q    <= '0;
			z_q    <= $signed({2'b00, angle[13:0], 16'b0});
			quad_q <= angle[15:14];
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		xc = x_q;
		yc = y_q;
		if (x_q > 20'sd65536)  xc = 20'sd65536;
		if (x_q < -20'sd65536) xc = -20'sd65536;
		if (y_q > 20'sd65536)  yc = 20'sd65536;
		if (y_q < -20'sd65536) yc = -20'sd65536;
		case (quad_q)
			2'd0: begin
				cos_o = xc[17:0];
				sin_o = yc[17:0];
			end
			2'd1: begin
				cos_o = 18'(-yc);
				sin_o = xc[17:0];
			end
			2'd2: begin
				cos_o = 18'(-xc);
				sin_o = 18'(-yc);
			end
			default: begin
				cos_o = yc[17:0];
				sin_o = 18'(-xc);
			end
		endcase
	end

	assign done = done_q;
endmodule

/* sv/gcr_grid.sv */
// ----------------------------------------------------------------------------
// gcr_grid
// Occupancy grid memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gcr_grid #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end
endmodule

/* sv/grid_ray_cast_range.sv */
// ----------------------------------------------------------------------------
// grid_ray_cast_range
// Occupancy grid ray caster: cell writes and range queries.
// ----------------------------------------------------------------------------
// A cell write is taken while the block is idle and gives no word back. A cast
// keeps the input stalled while the ray is walked to an occupied or unknown
// cell or off the grid, and until its result can enter the output register.
// The origin in cells comes from two restoring dividers, one per axis, each
// producing one of 42 quotient bits per cycle (the CORDIC runs alongside
// them), and each step of the walk passes ST_STEP, which forms the address
// and issues a grid memory read, and ST_READ, which tests the registered data.
// A finished result waits in an output register, so writes and the next cast
// may be taken while it is held.
module grid_ray_cast_range #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_stall,
	input  gcr_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output gcr_pkg::rsp_t  rsp
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = gcr_pkg::DIM_W;
	localparam int PW    = gcr_pkg::POS_W;

	gcr_pkg::state_t state_q, state_d;

	logic [8:0]  width_q, height_q;
	logic [15:0] cell_q;
	logic [DW-1:0] w_eff, h_eff;
	logic [15:0] cs_eff;

	logic signed [PW-1:0] px_q, py_q;
	logic [gcr_pkg::STEP_W-1:0] d_q, used_q;
	logic left_q;
	logic [7:0] tag_q;
	logic rsp_valid_q;
	gcr_pkg::rsp_t rsp_q;

	logic dx_done, dy_done, cd_done, start;
	logic [gcr_pkg::QUO_W-1:0] ox, oy;
	logic signed [gcr_pkg::TRIG_W-1:0] cos_v, sin_v;

	logic mem_we, mem_re;
	logic [AW-1:0] raddr;
	logic [7:0] rdata;
	logic outside, hit, slot_free, is_cast;
	logic [PW-18:0] colp, rowp;
	logic [DW-1:0] col, row;
	logic [2*DW-1:0] idx;
	logic [27:0] prod;
	logic [19:0] rng;

	assign w_eff  = ({4'b0, width_q} > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : {4'b0, width_q};
	assign h_eff  = ({4'b0, height_q} > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : {4'b0, height_q};
	assign cs_eff = (cell_q == 16'd0) ? 16'd1 : cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			cell_q   <= 16'd3277;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcr_pkg::REG_WIDTH:  width_q  <= cfg_data[8:0];
				gcr_pkg::REG_HEIGHT: height_q <= cfg_data[8:0];
				gcr_pkg::REG_CELL:   cell_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	gcr_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(start),
		.dividend({req.pos_x, 24'b0}), .divisor(cs_eff),
		.quotient(ox), .done(dx_done)
	);

	gcr_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(start),
		.dividend({req.pos_y, 24'b0}), .divisor(cs_eff),
		.quotient(oy), .done(dy_done)
	);

	gcr_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(start), .angle(req.angle),
		.cos_o(cos_v), .sin_o(sin_v), .done(cd_done)
	);

	gcr_grid #(.DEPTH(DEPTH), .AW(AW)) u_grid (
		.clk(clk), .we(mem_we), .waddr(AW'(req.cell_index)),
		.wdata(req.cell_value), .re(mem_re), .raddr(raddr), .rdata(rdata)
	);

	// A position in (-1, 0) truncates to cell zero and stays inside.
	assign colp = px_q[PW-1] ? '0 : px_q[PW-2:16];
	assign rowp = py_q[PW-1] ? '0 : py_q[PW-2:16];
	assign outside = (px_q <= -PW'(65536)) || (py_q <= -PW'(65536)) ||
		(colp >= (PW-17)'(w_eff)) || (rowp >= (PW-17)'(h_eff));
	assign col   = colp[DW-1:0];
	assign row   = rowp[DW-1:0];
	assign idx   = row * w_eff + (2*DW)'(col);
	assign raddr = idx[AW-1:0];
	assign hit   = ($signed(rdata) > gcr_pkg::OCC_LIMIT) || ($signed(rdata) == gcr_pkg::OCC_UNKNOWN);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign is_cast   = req.command == gcr_pkg::CMD_CAST;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gcr_pkg::ST_IDLE: if (req_valid && is_cast) state_d = gcr_pkg::ST_CALC;
			gcr_pkg::ST_CALC: if (dx_done && dy_done && cd_done) state_d = gcr_pkg::ST_STEP;
			gcr_pkg::ST_STEP: state_d = outside ? gcr_pkg::ST_DONE : gcr_pkg::ST_READ;
			gcr_pkg::ST_READ: state_d = hit ? gcr_pkg::ST_DONE : gcr_pkg::ST_STEP;
			gcr_pkg::ST_DONE: if (slot_free) state_d = gcr_pkg::ST_IDLE;
			default: state_d = gcr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = state_q != gcr_pkg::ST_IDLE;
		start     = (state_q == gcr_pkg::ST_IDLE) && req_valid && is_cast;
		mem_we    = (state_q == gcr_pkg::ST_IDLE) && req_valid && !is_cast &&
			(32'(req.cell_index) < 32'(DEPTH));
		mem_re    = (state_q == gcr_pkg::ST_STEP) && !outside;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gcr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (start)
			tag_q <= req.beam_index;
		if (state_q == gcr_pkg::ST_CALC) begin
			px_q <= $signed({3'b0, ox}) + PW'(cos_v);
			py_q <= $signed({3'b0, oy}) + PW'(sin_v);
			d_q  <= gcr_pkg::STEP_W'(1);
		end
		if (state_q == gcr_pkg::ST_STEP && outside) begin
			used_q <= d_q - gcr_pkg::STEP_W'(1);
			left_q <= 1'b1;
		end
		if (state_q == gcr_pkg::ST_READ) begin
			if (hit) begin
				used_q <= d_q;
				left_q <= 1'b0;
			end else begin
				px_q <= px_q + PW'(cos_v);
				py_q <= py_q + PW'(sin_v);
				d_q  <= d_q + gcr_pkg::STEP_W'(1);
			end
		end
	end

	assign prod = used_q * cs_eff;
	assign rng  = prod[27:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == gcr_pkg::ST_DONE && slot_free)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == gcr_pkg::ST_DONE && slot_free) begin
			rsp_q.range     <= (rng > 20'(gcr_pkg::RANGE_MAX)) ? gcr_pkg::RANGE_MAX : rng[17:0];
			rsp_q.steps     <= (used_q > gcr_pkg::STEP_W'(gcr_pkg::STEPS_MAX)) ?
				gcr_pkg::STEPS_MAX : used_q[8:0];
			rsp_q.left_grid <= left_q;
			rsp_q.beam_tag  <= tag_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_read_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> state_q == gcr_pkg::ST_READ)
		else $error("grid read not followed by data cycle");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == gcr_pkg::ST_IDLE && !mem_re)
		else $error("grid written during a cast");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == gcr_pkg::ST_DONE)
		else $error("result word without a finished cast");
endmodule

/* tb/grid_ray_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_ray_checker
// Watches the configuration port and both word channels of the grid ray
// caster, keeps its own copy of the grid and the registers, works out the
// range word that every accepted cast must give and compares each returned
// word with the oldest one due.
// ----------------------------------------------------------------------------
module grid_ray_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	input  logic           req_valid,
	input  logic           req_stall,
	input  gcr_pkg::req_t  req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  gcr_pkg::rsp_t  rsp,
	output int             fail_count,
	output int             pending
);
	logic signed [7:0] occ [0:65535];
	logic [8:0]        cols;
	logic [8:0]        rows;
	logic [15:0]       cell_len;
	gcr_pkg::rsp_t     ranges_due [$];

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
		fail_count++;
	endtask

	function automatic longint toward_zero(input longint v);
		if (v >= 0)
			return v >>> 16;
		return -((-v) >>> 16);
	endfunction

	function automatic longint unit_clamp(input longint v);
		if (v > 65536)
			return 65536;
		if (v < -65536)
			return -65536;
		return v;
	endfunction

	function automatic gcr_pkg::rsp_t cast_ray(input gcr_pkg::req_t q);
		longint            x, y, z, dx, dy, c, s, ox, oy, col, row;
		longint unsigned   cs, wid, hgt, d, used, span;
		logic signed [7:0] v;
		logic              out_of_grid;
		gcr_pkg::rsp_t     r;
		wid = (cols > 256) ? 256 : cols;
		hgt = (rows > 256) ? 256 : rows;
		cs = (cell_len == 0) ? 1 : cell_len;
		ox = longint'((longint'(q.pos_x) << 24) / cs);
		oy = longint'((longint'(q.pos_y) << 24) / cs);
		x = 39797;
		y = 0;
		z = longint'(q.angle[13:0]) << 16;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(gcr_pkg::atan_turn(i[3:0]));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(gcr_pkg::atan_turn(i[3:0]));
			end
		end
		x = unit_clamp(x);
		y = unit_clamp(y);
		case (q.angle[15:14])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		d = 1;
		out_of_grid = 1'b0;
		forever begin
			col = toward_zero(ox + longint'(d) * c);
			row = toward_zero(oy + longint'(d) * s);
			if (col < 0 || row < 0 || col >= longint'(wid) || row >= longint'(hgt)) begin
				out_of_grid = 1'b1;
				break;
			end
			v = occ[row * wid + col];
			if (v > gcr_pkg::OCC_LIMIT || v == gcr_pkg::OCC_UNKNOWN)
				break;
			d++;
		end
		used = out_of_grid ? d - 1 : d;
		span = (used * cs) >> 8;
		r.range = (span > gcr_pkg::RANGE_MAX) ? gcr_pkg::RANGE_MAX : span[17:0];
		r.steps = (used > gcr_pkg::STEPS_MAX) ? gcr_pkg::STEPS_MAX : used[8:0];
		r.left_grid = out_of_grid;
		r.beam_tag = q.beam_index;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gcr_pkg::rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < 65536; i++)
				occ[i] = '0;
			cols = 9'd256;
			rows = 9'd256;
			cell_len = 16'd3277;
			ranges_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (ranges_due.size() == 0) begin
					report("word with none due, range", rsp.range, -1);
				end else begin
					e = ranges_due.pop_front();
					if (rsp.range !== e.range)
						report("range", rsp.range, e.range);
					if (rsp.steps !== e.steps)
						report("steps", rsp.steps, e.steps);
					if (rsp.left_grid !== e.left_grid)
						report("left_grid", rsp.left_grid, e.left_grid);
					if (rsp.beam_tag !== e.beam_tag)
						report("beam_tag", rsp.beam_tag, e.beam_tag);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					gcr_pkg::REG_WIDTH:  cols = cfg_data[8:0];
					gcr_pkg::REG_HEIGHT: rows = cfg_data[8:0];
					gcr_pkg::REG_CELL:   cell_len = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				if (req.command == gcr_pkg::CMD_WRITE)
					occ[req.cell_index] = req.cell_value;
				else
					ranges_due = {ranges_due, cast_ray(req)};
			end
			pending = ranges_due.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the grid ray caster.
// Fills the first 400 cells, then runs directed casts and cell writes
// followed by random traffic under several register settings, with random
// idle bursts on both channels, one long output hold-off and occasional
// drain pauses. The checker beside the block predicts and compares every
// returned word.
// ----------------------------------------------------------------------------
module tb;
	localparam int LIMIT = 4000000;
	localparam int FILL  = 400;
	localparam int REQ_W = $bits(gcr_pkg::req_t);

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [15:0]   cfg_data;
	logic          req_valid;
	logic          req_stall;
	gcr_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	gcr_pkg::rsp_t rsp;
	int            fail_count;
	int            pending;
	int            cycles;
	logic          calm;
	logic          hold;
	logic          hold_go;
	int            cur_w;
	int            cur_cs;

	grid_ray_cast_range uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	grid_ray_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Output stall: random bursts, plus one long hold-off.
	always @(negedge clk) begin
		int burst;
		if (burst > 0)
			burst--;
		else if (!calm && $urandom_range(0, 7) == 0)
			burst = $urandom_range(1, 9);
		rsp_stall <= hold || (burst > 0);
	end

	initial begin
		hold = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold <= 1'b1;
		repeat (3000) @(negedge clk);
		hold <= 1'b0;
	end

	task automatic send(input gcr_pkg::req_t w);
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic write_cell(input logic [15:0] idx, input logic signed [7:0] v);
		gcr_pkg::req_t w;
		w = gcr_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom}));
		w.command = gcr_pkg::CMD_WRITE;
		w.cell_index = idx;
		w.cell_value = v;
		send(w);
	endtask

	task automatic cast(input logic [17:0] px, input logic [17:0] py, input logic [15:0] ang,
			input logic [7:0] beam);
		gcr_pkg::req_t w;
		w = gcr_pkg::req_t'(REQ_W'({$urandom, $urandom, $urandom}));
		w.command = gcr_pkg::CMD_CAST;
		w.pos_x = px;
		w.pos_y = py;
		w.angle = ang;
		w.beam_index = beam;
		send(w);
	endtask

	task automatic drain;
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [7:0] fill_value();
		int p;
		p = $urandom_range(0, 99);
		if (p < 88)
			return 8'($urandom_range(0, 50));
		if (p < 95)
			return 8'($urandom_range(51, 127));
		if (p < 97)
			return gcr_pkg::OCC_UNKNOWN;
		return 8'(-int'($urandom_range(2, 128)));
	endfunction

	function automatic logic [17:0] pick_pos();
		longint lim;
		if ($urandom_range(0, 9) == 0)
			return 18'($urandom);
		lim = (longint'(cur_w) * longint'(cur_cs)) / 256 + 2;
		if (lim > 262143)
			lim = 262143;
		return 18'($urandom_range(0, 32'(lim)));
	endfunction

	task automatic random_part(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 && $urandom_range(0, 3) == 0)
				drain();
			if ($urandom_range(0, 4) == 0)
				write_cell(16'($urandom), fill_value());
			else
				cast(pick_pos(), pick_pos(), 16'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		int ws [6];
		int hs [6];
		int css [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		hold_go = 1'b0;
		cur_w = 256;
		cur_cs = 3277;
		ws = '{1, 0, 511, 1, 16, 100};
		hs = '{1, 40, 1, 300, 25, 4};
		css = '{65535, 1000, 0, 256, 65535, 40000};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < FILL; i++)
			write_cell(16'(i), fill_value());

		cast(18'd0, 18'd0, 16'd0, 8'd200);
		drain();
		set_reg(gcr_pkg::REG_WIDTH, 16'd20);
		set_reg(gcr_pkg::REG_HEIGHT, 16'd20);
		cur_w = 20;

		write_cell(16'd0, 8'sd0);
		write_cell(16'd1, gcr_pkg::OCC_UNKNOWN);
		cast(18'd0, 18'd0, 16'd0, 8'd0);
		write_cell(16'd1, 8'sd127);
		cast(18'd0, 18'd0, 16'd0, 8'd255);
		write_cell(16'd1, -8'sd128);
		write_cell(16'd2, 8'sd100);
		cast(18'd0, 18'd0, 16'd0, 8'd1);
		write_cell(16'd65535, 8'sd50);
		cast(18'd0, 18'd0, 16'd32768, 8'd2);
		cast(18'd100, 18'd100, 16'd32768, 8'd3);
		cast(18'd0, 18'd0, 16'd16384, 8'd4);
		cast(18'd0, 18'd0, 16'd49152, 8'd5);
		cast(18'd0, 18'd0, 16'd8192, 8'd6);
		cast(18'd0, 18'd0, 16'd65535, 8'd7);
		cast(18'd262143, 18'd262143, 16'd0, 8'd8);
		cast(18'd1600, 18'd1600, 16'd40000, 8'd9);
		cast(18'd1600, 18'd1600, 16'd24576, 8'd10);
		cast(18'd3276, 18'd3276, 16'd57344, 8'd128);
		random_part(150);
		drain();

		for (int p = 0; p < 6; p++) begin
			set_reg(gcr_pkg::REG_WIDTH, 16'(ws[p]));
			set_reg(gcr_pkg::REG_HEIGHT, 16'(hs[p]));
			set_reg(gcr_pkg::REG_CELL, 16'(css[p]));
			cur_w = (ws[p] > 256) ? 256 : ws[p];
			cur_cs = (css[p] == 0) ? 1 : css[p];
			if (p == 4)
				hold_go = 1'b1;
			if (p == 5)
				calm = 1'b1;
			random_part(150);
			drain();
		end

		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
